### hw/rtl/spg_pkg.sv
`timescale 1ns / 1ps

package spg_pkg;

    typedef logic [2:0] t_mode;
    typedef logic [2:0] t_cfg_idx;

    localparam t_mode MODE_SINE      = 3'd0;
    localparam t_mode MODE_RAMP_UP   = 3'd1;
    localparam t_mode MODE_RAMP_DOWN = 3'd2;
    localparam t_mode MODE_TRIANGLE  = 3'd3;
    localparam t_mode MODE_SAW       = 3'd4;
    localparam t_mode MODE_NOISE     = 3'd5;

    localparam t_cfg_idx CFG_PROFILE_MODE = 3'd0;
    localparam t_cfg_idx CFG_CYCLE_LENGTH = 3'd1;
    localparam t_cfg_idx CFG_RUN_LENGTH   = 3'd2;
    localparam t_cfg_idx CFG_START_DELAY  = 3'd3;
    localparam t_cfg_idx CFG_AMP_X        = 3'd4;
    localparam t_cfg_idx CFG_AMP_Y        = 3'd5;
    localparam t_cfg_idx CFG_AMP_Z        = 3'd6;
    localparam t_cfg_idx CFG_SMOOTHING    = 3'd7;

    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [16:0] HALF_Q16 = 17'd32768;
    localparam logic [19:0] DRAW_SPAN = 20'd1000000;

    localparam logic [31:0] RST_CYCLE_LENGTH = 32'd6000000;
    localparam logic [31:0] RST_START_DELAY  = 32'd2000000;
    localparam logic [16:0] RST_AMP          = 17'd32768;
    localparam logic [16:0] RST_SMOOTHING    = 17'd19661;

endpackage

### hw/rtl/scale_profile_generator.sv
`timescale 1ns / 1ps
// Each accepted tick runs through a bit-serial divider: 33 steps for the period remainder and
// 33 + 16 (sine: 33 + log2 of four times the table depth) steps for the level quotient, then
// the multiplies; a ramp already at full scale and the constant profile skip the second division.
// One tick at a time: a new tick is accepted only once the last one has finished.
// Reset (synchronous, active low) restores register defaults, level one half, and not stopped.
module scale_profile_generator #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int TIME_WIDTH       = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,   // time_since_start[31:0], noise_draw[51:32]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // level[16:0], scale_x[34:17], scale_y[52:35], scale_z[70:53]
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int LD   = $clog2(SINE_TABLE_DEPTH);
    localparam int XW   = 33;
    localparam int CNTW = $clog2(XW + 17);
    localparam logic [31:0] TMASK =
        (TIME_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << TIME_WIDTH) - 64'd1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK1  = 4'd1;
    localparam logic [3:0] S_CHK2  = 4'd2;
    localparam logic [3:0] S_DIV1  = 4'd3;
    localparam logic [3:0] S_SETUP = 4'd4;
    localparam logic [3:0] S_DIV2  = 4'd5;
    localparam logic [3:0] S_ROM   = 4'd6;
    localparam logic [3:0] S_LVL   = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    typedef logic [15:0] t_rom [SINE_TABLE_DEPTH];

    function automatic logic [15:0] quarter_sine(input longint unsigned k);
        longint unsigned x, x2, term, pos, neg, sum, v;
        x    = (64'd1686629713 * k) / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = 0;
        for (int n = 1; n <= 7; n++) begin
            term = (term * x2) >> 30;
            case (n)
                1: term = term / 6;
                2: term = term / 20;
                3: term = term / 42;
                4: term = term / 72;
                5: term = term / 110;
                6: term = term / 156;
                default: term = term / 210;
            endcase
            if (n % 2 == 1) neg = neg + term;
            else pos = pos + term;
        end
        sum = (pos > neg) ? pos - neg : 64'd0;
        if (sum > (64'd1 << 30)) sum = 64'd1 << 30;
        v = (sum + (64'd1 << 13)) >> 14;
        return (v > 64'd65535) ? 16'hFFFF : 16'(v);
    endfunction

    function automatic t_rom build_rom();
        t_rom tab;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) tab[k] = quarter_sine(longint'(k));
        return tab;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    function automatic logic [16:0] sat_q16(input logic [16:0] v);
        return (v > spg_pkg::ONE_Q16) ? spg_pkg::ONE_Q16 : v;
    endfunction

    // configuration
    spg_pkg::t_mode r_mode;
    logic [31:0] r_cycle, r_run, r_delay;
    logic [16:0] r_amp_x, r_amp_y, r_amp_z, r_smooth;

    // control and datapath
    logic [3:0]      r_state, n_state;
    logic            r_stopped, n_stopped;
    logic [31:0]     r_t, n_t;
    logic [19:0]     r_draw, n_draw;
    logic [31:0]     r_el, n_el;
    logic [31:0]     r_r, n_r;
    logic            r_upfull, n_upfull;
    logic [XW-1:0]   r_num, n_num;
    logic [31:0]     r_den, n_den;
    logic [31:0]     r_rem, n_rem;
    logic [16:0]     r_quo, n_quo;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [15:0]     r_sin;
    logic [16:0]     r_lvl, n_lvl;
    logic [16:0]     r_last, n_last;
    logic [33:0]     r_acc, n_acc;
    logic [2:0]      r_mi, n_mi;
    logic [17:0]     r_sx, n_sx, r_sy, n_sy, r_sz, n_sz;
    logic            r_ovalid, n_ovalid;
    logic [71:0]     r_odata, n_odata;

    logic [31:0]   cyc, dur;
    logic [32:0]   rem_sh, rem_diff;
    logic          rem_ge;
    logic [1:0]    sq;
    logic [LD-1:0] sj, rom_addr;
    logic [16:0]   sin_s;
    logic [17:0]   sin_lvl;
    logic [16:0]   mul_a, mul_b;
    logic [33:0]   prod;
    logic [16:0]   amp_sel;
    logic [17:0]   scale;
    logic [32:0]   r2;
    logic [19:0]   draw_red;

    assign cyc = (r_cycle == 32'd0) ? 32'd1 : r_cycle;
    assign dur = (r_run != 32'd0) ? r_run : cyc;

    // one restoring division step per cycle
    assign rem_sh   = {r_rem, r_num[XW-1]};
    assign rem_diff = rem_sh - {1'b0, r_den};
    assign rem_ge   = (rem_sh >= {1'b0, r_den});

    // sine quadrant handling
    assign sq       = r_quo[LD+1:LD];
    assign sj       = r_quo[LD-1:0];
    assign rom_addr = sq[0] ? (~sj + 1'b1) : sj;
    assign sin_s    = (sq[0] && sj == '0) ? spg_pkg::ONE_Q16 : {1'b0, r_sin};
    assign sin_lvl  = sq[1] ? ((18'(spg_pkg::ONE_Q16) - 18'(sin_s)) >> 1)
                            : ((18'(spg_pkg::ONE_Q16) + 18'(sin_s)) >> 1);

    assign r2       = {r_r, 1'b0};
    assign draw_red = (r_draw >= spg_pkg::DRAW_SPAN) ? r_draw - spg_pkg::DRAW_SPAN : r_draw;

    // shared multiplier
    always_comb begin
        case (r_mi)
            3'd0:    amp_sel = sat_q16(r_smooth);
            3'd1:    amp_sel = sat_q16(r_smooth);
            3'd2:    amp_sel = sat_q16(r_amp_x);
            3'd3:    amp_sel = sat_q16(r_amp_y);
            default: amp_sel = sat_q16(r_amp_z);
        endcase
        case (r_mi)
            3'd0: begin
                mul_a = spg_pkg::ONE_Q16 - amp_sel;
                mul_b = r_last;
            end
            3'd1: begin
                mul_a = amp_sel;
                mul_b = r_quo;
            end
            default: begin
                mul_a = amp_sel;
                mul_b = r_lvl;
            end
        endcase
    end

    assign prod  = 34'(mul_a) * 34'(mul_b);
    assign scale = 18'(spg_pkg::ONE_Q16) - 18'(amp_sel) + 18'((prod + 34'd16384) >> 15);

    always_ff @(posedge i_clk) begin
        r_sin <= SINE_ROM[rom_addr];
    end

    always_comb begin
        n_state   = r_state;
        n_stopped = r_stopped;
        n_t       = r_t;
        n_draw    = r_draw;
        n_el      = r_el;
        n_r       = r_r;
        n_upfull  = r_upfull;
        n_num     = r_num;
        n_den     = r_den;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_cnt     = r_cnt;
        n_lvl     = r_lvl;
        n_last    = r_last;
        n_acc     = r_acc;
        n_mi      = r_mi;
        n_sx      = r_sx;
        n_sy      = r_sy;
        n_sz      = r_sz;
        n_ovalid  = r_ovalid;
        n_odata   = r_odata;

        if (r_ovalid && i_m_tready) n_ovalid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_t     = i_s_tdata[31:0] & TMASK;
                    n_draw  = i_s_tdata[51:32];
                    n_state = S_CHK1;
                end
            end
            S_CHK1: begin
                if (r_stopped || r_t < r_delay) n_state = S_IDLE;
                else begin
                    n_el    = r_t - r_delay;
                    n_state = S_CHK2;
                end
            end
            S_CHK2: begin
                if (r_run != 32'd0 && r_el >= r_run) begin
                    n_stopped = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_upfull = (r_el >= dur);
                    n_num    = {1'b0, r_el};
                    n_den    = cyc;
                    n_rem    = '0;
                    n_quo    = '0;
                    n_cnt    = CNTW'(XW - 1);
                    n_state  = S_DIV1;
                end
            end
            S_DIV1, S_DIV2: begin
                n_num = {r_num[XW-2:0], 1'b0};
                n_rem = rem_ge ? rem_diff[31:0] : rem_sh[31:0];
                n_quo = {r_quo[15:0], rem_ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    if (r_state == S_DIV1) begin
                        n_r     = n_rem;
                        n_state = S_SETUP;
                    end else begin
                        n_state = S_ROM;
                    end
                end
            end
            S_SETUP: begin
                // The dividend is shifted left by feeding zeros after its last bit.
                n_rem   = '0;
                n_quo   = '0;
                n_den   = cyc;
                n_num   = {1'b0, r_r};
                n_cnt   = CNTW'(XW + 15);
                n_state = S_DIV2;
                case (r_mode)
                    spg_pkg::MODE_SINE: begin
                        n_cnt = CNTW'(XW + LD + 1);
                    end
                    spg_pkg::MODE_RAMP_UP, spg_pkg::MODE_RAMP_DOWN: begin
                        n_num = {1'b0, r_el};
                        n_den = dur;
                        if (r_upfull) n_state = S_LVL;
                    end
                    spg_pkg::MODE_TRIANGLE: begin
                        n_num = (r2 < {1'b0, cyc}) ? r2 : {cyc - r_r, 1'b0};
                    end
                    spg_pkg::MODE_SAW: begin
                    end
                    spg_pkg::MODE_NOISE: begin
                        n_num = XW'(draw_red);
                        n_den = 32'(spg_pkg::DRAW_SPAN);
                    end
                    default: n_state = S_LVL;
                endcase
            end
            S_ROM: begin
                n_state = S_LVL;
            end
            S_LVL: begin
                n_mi    = 3'd2;
                n_state = S_MUL;
                case (r_mode)
                    spg_pkg::MODE_SINE:      n_lvl = sat_q16(sin_lvl[16:0]);
                    spg_pkg::MODE_RAMP_UP:   n_lvl = r_upfull ? spg_pkg::ONE_Q16 : r_quo;
                    spg_pkg::MODE_RAMP_DOWN: n_lvl = r_upfull ? 17'd0
                                                              : spg_pkg::ONE_Q16 - r_quo;
                    spg_pkg::MODE_TRIANGLE:  n_lvl = sat_q16(r_quo);
                    spg_pkg::MODE_SAW:       n_lvl = sat_q16(r_quo);
                    spg_pkg::MODE_NOISE:     n_mi  = 3'd0;
                    default:                 n_lvl = spg_pkg::HALF_Q16;
                endcase
            end
            S_MUL: begin
                n_mi = r_mi + 1'b1;
                case (r_mi)
                    3'd0: n_acc = prod;
                    3'd1: n_lvl = sat_q16(17'((r_acc + prod + 34'd32768) >> 16));
                    3'd2: n_sx = scale;
                    3'd3: n_sy = scale;
                    default: begin
                        n_sz    = scale;
                        n_state = S_OUT;
                    end
                endcase
            end
            S_OUT: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {1'b0, r_sz, r_sy, r_sx, r_lvl};
                    n_last   = r_lvl;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_stopped <= 1'b0;
            r_last    <= spg_pkg::HALF_Q16;
            r_ovalid  <= 1'b0;
            r_mode    <= spg_pkg::MODE_SINE;
            r_cycle   <= spg_pkg::RST_CYCLE_LENGTH;
            r_run     <= '0;
            r_delay   <= spg_pkg::RST_START_DELAY;
            r_amp_x   <= spg_pkg::RST_AMP;
            r_amp_y   <= spg_pkg::RST_AMP;
            r_amp_z   <= spg_pkg::RST_AMP;
            r_smooth  <= spg_pkg::RST_SMOOTHING;
        end else begin
            r_state   <= n_state;
            r_stopped <= n_stopped;
            r_last    <= n_last;
            r_ovalid  <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    spg_pkg::CFG_PROFILE_MODE: r_mode   <= i_cfg_data[2:0];
                    spg_pkg::CFG_CYCLE_LENGTH: r_cycle  <= i_cfg_data;
                    spg_pkg::CFG_RUN_LENGTH:   r_run    <= i_cfg_data;
                    spg_pkg::CFG_START_DELAY:  r_delay  <= i_cfg_data;
                    spg_pkg::CFG_AMP_X:        r_amp_x  <= i_cfg_data[16:0];
                    spg_pkg::CFG_AMP_Y:        r_amp_y  <= i_cfg_data[16:0];
                    spg_pkg::CFG_AMP_Z:        r_amp_z  <= i_cfg_data[16:0];
                    default:                   r_smooth <= i_cfg_data[16:0];
                endcase
            end
        end
        r_t      <= n_t;
        r_draw   <= n_draw;
        r_el     <= n_el;
        r_r      <= n_r;
        r_upfull <= n_upfull;
        r_num    <= n_num;
        r_den    <= n_den;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_cnt    <= n_cnt;
        r_lvl    <= n_lvl;
        r_acc    <= n_acc;
        r_mi     <= n_mi;
        r_sx     <= n_sx;
        r_sy     <= n_sy;
        r_sz     <= n_sz;
        r_odata  <= n_odata;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV1 || r_state == S_DIV2) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[16:0] <= spg_pkg::ONE_Q16))
        else $error("level above one");

    a_stopped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> (r_state != S_SETUP && r_state != S_OUT))
        else $error("tick processed after stop");

    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_stopped) && $past(i_rst_n) |-> r_stopped)
        else $error("stop flag cleared without reset");

endmodule

### bench/spg_checker.sv
`timescale 1ns / 1ps

module spg_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [55:0] i_s_tdata,   // time_since_start[31:0], noise_draw[51:32]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [71:0] i_m_tdata,   // level[16:0], scale_x[34:17], scale_y[52:35], scale_z[70:53]
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    localparam int TABLE_DEPTH = 1024;

    typedef struct packed {
        logic [17:0] scale_z;
        logic [17:0] scale_y;
        logic [17:0] scale_x;
        logic [16:0] level;
    } t_scales;

    t_scales expected_q[$];

    bit [15:0] quarter_rom[TABLE_DEPTH];

    bit [2:0]  cfg_mode;
    bit [31:0] cfg_cycle;
    bit [31:0] cfg_run;
    bit [31:0] cfg_delay;
    bit [16:0] cfg_amp_x;
    bit [16:0] cfg_amp_y;
    bit [16:0] cfg_amp_z;
    bit [16:0] cfg_smooth;
    bit [63:0] held_level;
    bit        halted;

    // Quarter-wave sine by a Q30 Taylor series, same rounding as the hardware table.
    function automatic bit [15:0] quarter_sine(int k);
        bit [63:0] x, x2, term, pos, neg, sum, v;
        x = (64'd1686629713 * 64'(k)) / TABLE_DEPTH;
        x2 = (x * x) >> 30;
        term = x;
        pos = x;
        neg = 0;
        for (int n = 1; n <= 7; n++) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) neg += term;
            else pos += term;
        end
        sum = (pos > neg) ? pos - neg : 0;
        if (sum > (64'd1 << 30)) sum = 64'd1 << 30;
        v = (sum + (64'd1 << 13)) >> 14;
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic bit [63:0] sat_one(bit [63:0] v);
        return (v > 65536) ? 64'd65536 : v;
    endfunction

    function automatic bit [17:0] axis_scale(bit [16:0] amp, bit [63:0] lvl);
        bit [63:0] a;
        a = sat_one(64'(amp));
        return 18'(65536 - a + ((2 * a * lvl + 32768) >> 16));
    endfunction

    function automatic bit next_scales(bit [31:0] tick, bit [19:0] draw_in, output t_scales res);
        bit [63:0] draw, cyc, el, r, dur, up, v, i, q, j, s, a, target;
        res = '0;
        draw = 64'(draw_in) % 1000000;
        cyc = (cfg_cycle != 0) ? 64'(cfg_cycle) : 64'd1;
        if (halted || tick < cfg_delay) return 0;
        el = 64'(tick - cfg_delay);
        if (cfg_run != 0 && el >= cfg_run) begin
            halted = 1;
            return 0;
        end
        r = el % cyc;
        dur = (cfg_run != 0) ? 64'(cfg_run) : 64'(cfg_cycle);
        if (dur == 0) dur = 1;
        up = (el >= dur) ? 64'd65536 : (el * 65536) / dur;
        case (spg_pkg::t_mode'(cfg_mode))
            spg_pkg::MODE_SINE: begin
                i = (r * 4 * TABLE_DEPTH) / cyc;
                q = (i / TABLE_DEPTH) & 3;
                j = i % TABLE_DEPTH;
                if (q == 0 || q == 2) s = quarter_rom[j];
                else s = (j == 0) ? 64'd65536 : 64'(quarter_rom[TABLE_DEPTH - j]);
                v = (q < 2) ? (65536 + s) >> 1 : (65536 - s) >> 1;
            end
            spg_pkg::MODE_RAMP_UP:   v = up;
            spg_pkg::MODE_RAMP_DOWN: v = 65536 - up;
            spg_pkg::MODE_TRIANGLE: begin
                if (2 * r < cyc) v = (2 * r * 65536) / cyc;
                else v = (2 * (cyc - r) * 65536) / cyc;
            end
            spg_pkg::MODE_SAW: v = (r * 65536) / cyc;
            spg_pkg::MODE_NOISE: begin
                a = sat_one(64'(cfg_smooth));
                target = (draw * 65536) / 1000000;
                v = ((65536 - a) * held_level + a * target + 32768) >> 16;
            end
            default: v = 32768;
        endcase
        v = sat_one(v);
        held_level = v;
        res.level = v[16:0];
        res.scale_x = axis_scale(cfg_amp_x, v);
        res.scale_y = axis_scale(cfg_amp_y, v);
        res.scale_z = axis_scale(cfg_amp_z, v);
        return 1;
    endfunction

    task automatic check_field(string name, bit [17:0] exp_v, bit [17:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            o_errors++;
        end
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        for (int k = 0; k < TABLE_DEPTH; k++) quarter_rom[k] = quarter_sine(k);
    end

    always @(posedge i_clk) begin
        t_scales res, got;
        if (!i_rst_n) begin
            cfg_mode = 0;
            cfg_cycle = spg_pkg::RST_CYCLE_LENGTH;
            cfg_run = 0;
            cfg_delay = spg_pkg::RST_START_DELAY;
            cfg_amp_x = spg_pkg::RST_AMP;
            cfg_amp_y = spg_pkg::RST_AMP;
            cfg_amp_z = spg_pkg::RST_AMP;
            cfg_smooth = spg_pkg::RST_SMOOTHING;
            held_level = 32768;
            halted = 0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (spg_pkg::t_cfg_idx'(i_cfg_idx))
                    spg_pkg::CFG_PROFILE_MODE: cfg_mode = i_cfg_data[2:0];
                    spg_pkg::CFG_CYCLE_LENGTH: cfg_cycle = i_cfg_data;
                    spg_pkg::CFG_RUN_LENGTH:   cfg_run = i_cfg_data;
                    spg_pkg::CFG_START_DELAY:  cfg_delay = i_cfg_data;
                    spg_pkg::CFG_AMP_X:        cfg_amp_x = i_cfg_data[16:0];
                    spg_pkg::CFG_AMP_Y:        cfg_amp_y = i_cfg_data[16:0];
                    spg_pkg::CFG_AMP_Z:        cfg_amp_z = i_cfg_data[16:0];
                    spg_pkg::CFG_SMOOTHING:    cfg_smooth = i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                if (next_scales(i_s_tdata[31:0], i_s_tdata[51:32], res))
                    expected_q.push_back(res);
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[70:0];
                if (expected_q.size() == 0) begin
                    $error("unexpected result transaction: level %0d", got.level);
                    o_errors++;
                end else begin
                    res = expected_q.pop_front();
                    check_field("level", 18'(res.level), 18'(got.level));
                    check_field("scale_x", res.scale_x, got.scale_x);
                    check_field("scale_y", res.scale_y, got.scale_y);
                    check_field("scale_z", res.scale_z, got.scale_z);
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_tvalid = 0;
    logic        o_s_tready;
    logic [55:0] i_s_tdata = '0;   // time_since_start[31:0], noise_draw[51:32]
    logic        o_m_tvalid;
    logic        i_m_tready = 0;
    logic [71:0] o_m_tdata;        // level[16:0], scale_x[34:17], scale_y[52:35], scale_z[70:53]
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    int errors;
    int pending;
    int quiet_cycles = 0;
    bit gaps_on = 1;
    bit hold_sink = 0;

    scale_profile_generator i_dut (.*);

    spg_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .i_m_tdata(o_m_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Stall watchdog: any accepted transaction restarts the count.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= 20000) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Result sink with random back-pressure and one long hold-off on request.
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_sink) begin
                i_m_tready <= 0;
                repeat (400) @(posedge i_clk);
                hold_sink = 0;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                i_m_tready <= 0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_tick(bit [31:0] tick, bit [19:0] draw);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tdata <= {4'd0, draw, tick};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Drop valid, drain all results, then let a resultless tick finish.
    task automatic drain;
        i_s_tvalid <= 0;
        wait (pending == 0);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic load_profile(bit [2:0] mode, bit [31:0] cyc, bit [31:0] run, bit [31:0] delay,
                                bit [16:0] ax, bit [16:0] ay, bit [16:0] az, bit [16:0] sm);
        bit [31:0] vals[8];
        vals = '{32'(mode), cyc, run, delay, 32'(ax), 32'(ay), 32'(az), 32'(sm)};
        drain();
        for (int k = 0; k < 8; k++) begin
            i_cfg_we <= 1;
            i_cfg_idx <= spg_pkg::t_cfg_idx'(k);
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 0;
    endtask

    function automatic bit [16:0] pick_q16();
        case ($urandom_range(0, 5))
            0: return 17'd0;
            1: return spg_pkg::ONE_Q16;
            2: return 17'h1FFFF;
            default: return 17'($urandom_range(0, 131071));
        endcase
    endfunction

    function automatic bit [19:0] pick_draw();
        case ($urandom_range(0, 7))
            0: return 20'd0;
            1: return 20'd999999;
            2: return 20'($urandom);
            default: return 20'($urandom_range(0, 999999));
        endcase
    endfunction

    task automatic random_phase(int count, bit [2:0] mode, bit hold_first);
        bit [31:0] cyc, run, delay, off, tick;
        case ($urandom_range(0, 6))
            0: cyc = 0;
            1: cyc = 1;
            2: cyc = 32'hFFFFFFFF;
            3: cyc = $urandom_range(2, 5000);
            default: cyc = $urandom;
        endcase
        run = ($urandom_range(0, 2) == 0) ? 32'd0 : ($urandom | 32'd1);
        case ($urandom_range(0, 5))
            0: delay = 0;
            1: delay = $urandom_range(1, 1000);
            default: delay = $urandom >> $urandom_range(0, 31);
        endcase
        load_profile(mode, cyc, run, delay, pick_q16(), pick_q16(), pick_q16(), pick_q16());
        // The sink holds off while ticks keep coming, so the input stalls.
        if (hold_first) hold_sink = 1;
        for (int n = 0; n < count; n++) begin
            if (delay != 0 && $urandom_range(0, 9) == 0) begin
                tick = $urandom % delay;
            end else if (run == 0 && $urandom_range(0, 5) == 0) begin
                tick = $urandom;
            end else begin
                off = $urandom;
                if (run != 0) off = off % run;
                else if ($urandom_range(0, 1) == 0 && cyc != 0) off = off % (cyc * 2 + 1);
                tick = delay + off;
                if (tick < delay) tick = delay;
            end
            send_tick(tick, pick_draw());
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Reset profile: before the delay, at the delay, far beyond.
        send_tick(32'd0, 20'd0);
        send_tick(32'd2000000, 20'd999999);
        send_tick(32'hFFFFFFFF, 20'hFFFFF);
        send_tick(32'd5000000, 20'd500000);

        // Every mode once, including the unused codes, with extreme settings.
        for (int m = 0; m < 8; m++) begin
            load_profile(3'(m), 32'd1000, 32'd0, 32'd0, 17'd0, spg_pkg::ONE_Q16, 17'h1FFFF,
                         17'h1FFFF);
            send_tick(32'd0, 20'd0);
            send_tick(32'd250, 20'd999999);
            send_tick(32'd750, 20'hFFFFF);
        end
        // Zero cycle length, zero duration ramp, near-maximal delay and maximal run length.
        load_profile(spg_pkg::MODE_RAMP_UP, 32'd0, 32'd0, 32'd0, spg_pkg::ONE_Q16, 17'd0, 17'd1,
                     17'd0);
        send_tick(32'd0, 20'd1);
        send_tick(32'd7, 20'd2);
        load_profile(spg_pkg::MODE_SINE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFE,
                     17'd12345, 17'd65535, spg_pkg::ONE_Q16, 17'd1);
        send_tick(32'hFFFFFFFE, 20'd3);
        send_tick(32'hFFFFFFFF, 20'd4);
        load_profile(spg_pkg::MODE_NOISE, 32'd1, 32'd0, 32'd0, spg_pkg::RST_AMP, spg_pkg::RST_AMP,
                     spg_pkg::RST_AMP, 17'd0);
        send_tick(32'hAAAAAAAA, 20'h55555);

        for (int ph = 0; ph < 16; ph++) begin
            if (ph >= 14) gaps_on = 0;
            random_phase(100, 3'(ph % 8), ph == 3);
        end

        // Run length elapses: the stop tick and everything after give nothing.
        load_profile(spg_pkg::MODE_RAMP_DOWN, 32'd300, 32'd1000, 32'd100,
                     17'd40000, 17'd20000, 17'd65536, 17'd100);
        send_tick(32'd500, 20'd0);
        send_tick(32'd1099, 20'd0);
        send_tick(32'd1100, 20'd0);
        send_tick(32'd500, 20'd0);
        send_tick(32'd600, 20'd0);

        drain();
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
